@@ design/wgm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wgm_pkg;

  localparam int MaxCols  = 1024;
  localparam int MaxRows  = 1024;
  localparam int WordBits = 32;
  localparam int IdxBits  = 10;
  localparam int CntBits  = 11;
  localparam int CmdBits  = 3;

  localparam logic signed [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};

  typedef enum logic [CmdBits-1:0] {
    CMD_START  = 3'd0,
    CMD_LOAD_X = 3'd1,
    CMD_LOAD_W = 3'd2,
    CMD_ELEM   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    cmd_t                        cmd;
    logic [IdxBits-1:0]          idx;
    logic signed [WordBits-1:0]  val;
  } job_t;

  localparam int JobBits = $bits(job_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DOT,
    ST_SCALE,
    ST_UPDATE,
    ST_READ,
    ST_EMIT
  } state_t;

  // Saturate a sum of two words.
  function automatic logic signed [WordBits-1:0] sat_add(
      input logic signed [WordBits-1:0] a, input logic signed [WordBits-1:0] b);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) sat_add = s[WordBits] ? WordMin : WordMax;
    else sat_add = s[WordBits-1:0];
  endfunction

  // Round a full product (add half, arithmetic shift) and saturate.
  function automatic logic signed [WordBits-1:0] q_round(
      input logic signed [2*WordBits-1:0] p);
    logic signed [2*WordBits:0] r;
    logic signed [2*WordBits:0] q;
    r = {p[2*WordBits-1], p} + (2*WordBits+1)'(32768);
    q = r >>> 16;
    if (q > $signed({{(WordBits+1){1'b0}}, WordMax})) q_round = WordMax;
    else if (q < $signed({{(WordBits+1){1'b1}}, WordMin})) q_round = WordMin;
    else q_round = q[WordBits-1:0];
  endfunction

endpackage
`default_nettype wire

@@ design/wgm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wgm_queue
  import wgm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire job_t in_job,
  output logic      out_valid,
  input  wire logic out_ready,
  output job_t      out_job
);

  // Four-entry queue between front and back.
  job_t       mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       push, pop;

  assign in_ready  = (count != 3'd4);
  assign out_valid = (count != 3'd0);
  assign out_job   = mem[rptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ design/wgm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wgm_front
  import wgm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [47:0]         s_axis_tdata,
  input  wire logic [CntBits-1:0]  rows_eff,
  output logic                     job_valid,
  input  wire logic                job_ready,
  output job_t                     job
);

  logic [CmdBits-1:0] cmd_raw;
  logic [IdxBits-1:0] idx;
  logic               keep;

  assign cmd_raw = s_axis_tdata[CmdBits-1:0];
  assign idx     = s_axis_tdata[CmdBits+IdxBits-1:CmdBits];

  // Drop unused codes and out-of-range reads here so the back never sees them.
  always_comb begin
    case (cmd_raw)
      CMD_START, CMD_LOAD_X, CMD_LOAD_W, CMD_ELEM: keep = 1'b1;
      CMD_READ: keep = ({1'b0, idx} < rows_eff);
      default:  keep = 1'b0;
    endcase
  end

  assign s_axis_tready = job_ready;
  assign job_valid     = s_axis_tvalid && keep;
  assign job.cmd = cmd_t'(cmd_raw);
  assign job.idx = idx;
  assign job.val = s_axis_tdata[CmdBits+IdxBits+WordBits-1:CmdBits+IdxBits];

  logic unused;
  assign unused = clk ^ rst ^ (|s_axis_tdata[47:45]);

endmodule
`default_nettype wire

@@ design/wgm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wgm_back
  import wgm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [CntBits-1:0] rows_eff,
  input  wire logic [CntBits-1:0] cols_eff,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  wire job_t               job,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [47:0]             m_axis_tdata
);

  // Stores, each read through a registered port.
  logic signed [WordBits-1:0] xmem [MaxCols];
  logic signed [WordBits-1:0] wmem [MaxRows];
  logic signed [WordBits-1:0] amem [MaxCols];
  logic signed [WordBits-1:0] rbuf [2*MaxCols];

  state_t state, state_next;
  job_t   cur;
  logic [CntBits-1:0] row_pos, col_pos, sweep;
  logic signed [WordBits-1:0] dot, scaled;
  logic signed [WordBits-1:0] xq, wq, aq, rq;
  logic signed [2*WordBits-1:0] prod;
  logic [1:0] phase;
  logic [IdxBits-1:0] out_idx;
  logic signed [WordBits-1:0] out_val;
  logic out_full;
  logic bank;
  logic last_col;

  assign bank = row_pos[0];
  assign last_col = (col_pos + 11'd1 >= cols_eff);
  assign job_ready = (state == ST_IDLE);
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = {6'b0, out_val, out_idx};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (job_valid) begin
        unique case (job.cmd)
          CMD_START: state_next = ST_CLEAR;
          CMD_ELEM:  state_next = (row_pos >= rows_eff) ? ST_IDLE : ST_DOT;
          CMD_READ:  state_next = ST_READ;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_CLEAR:  if (sweep == 11'(MaxCols - 1)) state_next = ST_IDLE;
      ST_DOT:    if (phase == 2'd2) state_next = last_col ? ST_SCALE : ST_IDLE;
      ST_SCALE:  if (phase == 2'd2) state_next = ST_UPDATE;
      ST_UPDATE: if (phase == 2'd3 && sweep + 11'd1 >= cols_eff) state_next = ST_IDLE;
      ST_READ:   if (phase != 2'd0 && !out_full) state_next = ST_EMIT;
      ST_EMIT:   if (!out_full) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Registered memory reads.
  always_ff @(posedge clk) begin
    xq <= xmem[(state == ST_IDLE) ? job.idx : col_pos[IdxBits-1:0]];
    wq <= wmem[(state == ST_READ) ? cur.idx : row_pos[IdxBits-1:0]];
    aq <= amem[(state == ST_READ) ? cur.idx : sweep[IdxBits-1:0]];
    rq <= rbuf[{bank, sweep[IdxBits-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) begin
      if (job.cmd == CMD_LOAD_X) xmem[job.idx] <= job.val;
      if (job.cmd == CMD_LOAD_W) wmem[job.idx] <= job.val;
      if (job.cmd == CMD_ELEM && row_pos < rows_eff)
        rbuf[{bank, col_pos[IdxBits-1:0]}] <= job.val;
    end
    if (state == ST_CLEAR) amem[sweep[IdxBits-1:0]] <= '0;
    if (state == ST_UPDATE && phase == 2'd3)
      amem[sweep[IdxBits-1:0]] <= sat_add(aq, q_round(prod));
  end

  // Datapath and counters. Reset starts with a sweep that zeroes the accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR; row_pos <= '0; col_pos <= '0; dot <= '0;
      sweep <= '0; phase <= '0; out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (out_full && m_axis_tready) out_full <= 1'b0;
      if (state_next != state) phase <= '0;
      else phase <= phase + 2'd1;
      unique case (state)
        ST_IDLE: begin
          cur <= job;
          sweep <= '0;
          if (job_valid && job.cmd == CMD_START) begin
            row_pos <= '0; col_pos <= '0; dot <= '0;
          end
        end
        ST_CLEAR: sweep <= sweep + 11'd1;
        ST_DOT: begin
          // phase 0: read xq; 1: product; 2: accumulate
          if (phase == 2'd1) prod <= 64'(cur.val) * 64'(xq);
          if (phase == 2'd2) begin
            if (last_col) dot <= sat_add(dot, q_round(prod));
            else begin
              dot <= sat_add(dot, q_round(prod));
              col_pos <= col_pos + 11'd1;
            end
          end
        end
        ST_SCALE: begin
          if (phase == 2'd1) prod <= 64'(dot) * 64'(wq);
          if (phase == 2'd2) begin
            scaled <= q_round(prod);
            sweep <= '0;
          end
        end
        ST_UPDATE: begin
          // phase 0 addr, 1 data, 2 multiply, 3 write back
          if (phase == 2'd2) prod <= 64'(rq) * 64'(scaled);
          if (phase == 2'd3) begin
            sweep <= sweep + 11'd1;
            if (sweep + 11'd1 >= cols_eff) begin
              dot <= '0; col_pos <= '0; row_pos <= row_pos + 11'd1;
            end
          end
        end
        // The result register is loaded only once the previous item has left.
        ST_READ: if (phase != 2'd0 && !out_full) begin
          out_idx <= cur.idx;
          out_val <= sat_add(({1'b0, cur.idx} < cols_eff) ? aq : '0, wq);
        end
        ST_EMIT: if (!out_full) out_full <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/weighted_gram_matrix_vector_product_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Computes y = A^T diag(d) (A x) + d in Q16.16 with saturation. Load x and d, send start,
// stream A row-major, then read outputs. After reset the block zeroes the accumulators
// before it takes work. Commands enter a four-entry queue; the back end handles one at a
// time: the last element of a row adds a column update through the single accumulator
// port, a read takes longer while an earlier result waits, and start runs a clearing sweep.
module weighted_gram_matrix_vector_product_top
  import wgm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // command[2:0], index[12:3], value[44:13]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // out_index[9:0], out_value[41:10]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data
);

  logic [CntBits-1:0] row_count, column_count, rows_eff, cols_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 11'd1024; column_count <= 11'd1024;
    end else if (cfg_we) begin
      if (cfg_index) column_count <= cfg_data;
      else row_count <= cfg_data;
    end
  end

  // Clamp to 1..1024.
  assign rows_eff = (row_count == '0) ? 11'd1 : (row_count > 11'd1024 ? 11'd1024 : row_count);
  assign cols_eff = (column_count == '0) ? 11'd1 :
                    (column_count > 11'd1024 ? 11'd1024 : column_count);

  logic fv, fr, qv, qr;
  job_t fj, qj;

  wgm_front u_front (.clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .rows_eff, .job_valid(fv), .job_ready(fr), .job(fj));
  wgm_queue u_queue (.clk, .rst, .in_valid(fv), .in_ready(fr), .in_job(fj),
    .out_valid(qv), .out_ready(qr), .out_job(qj));
  wgm_back u_back (.clk, .rst, .rows_eff, .cols_eff, .job_valid(qv), .job_ready(qr),
    .job(qj), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

endmodule
`default_nettype wire

@@ bench/wgm_tb_pkg.sv @@
`timescale 1ns / 1ps
package wgm_tb_pkg;

  // Register indexes on the configuration port.
  localparam logic RegRowCount    = 1'b0;
  localparam logic RegColumnCount = 1'b1;

  // Command codes that the block ignores.
  localparam int UnusedCmdFirst = 5;
  localparam int UnusedCmdLast  = 7;

  // Expected read result.
  typedef struct {
    logic [9:0]         idx;
    logic signed [31:0] val;
  } read_result_t;

endpackage

@@ bench/wgm_checker.sv @@
`timescale 1ns / 1ps
module wgm_checker
  import wgm_pkg::*;
  import wgm_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          results
);

  logic signed [31:0] x_vec [MaxCols];
  logic signed [31:0] weight [MaxRows];
  logic signed [31:0] col_acc [MaxCols];
  logic signed [31:0] row_buf [2*MaxCols];
  int unsigned        row_pos, col_pos;
  logic signed [31:0] dot_sum;
  logic [10:0]        rows_reg, cols_reg;
  read_result_t       expected_reads [$];

  function automatic logic signed [31:0] clip(input logic signed [64:0] v);
    if (v > 65'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -65'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return clip(65'(a) + 65'(b));
  endfunction

  // Exact product, round half up, then saturate.
  function automatic logic signed [31:0] mul_q16(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [64:0] p;
    p = 65'(a) * 65'(b) + 65'sd32768;
    return clip(p >>> 16);
  endfunction

  function automatic int unsigned clamp_size(input logic [10:0] v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one accepted command to the predicted state.
  task automatic apply_command(input logic [47:0] d);
    logic [2:0]         cmd;
    logic [9:0]         idx;
    logic signed [31:0] val, scaled;
    int unsigned        nrows, ncols, bank;
    read_result_t       r;
    cmd   = d[2:0];
    idx   = d[12:3];
    val   = d[44:13];
    nrows = clamp_size(rows_reg, MaxRows);
    ncols = clamp_size(cols_reg, MaxCols);
    case (cmd)
      CMD_START: begin
        foreach (col_acc[j]) col_acc[j] = '0;
        row_pos = 0;
        col_pos = 0;
        dot_sum = '0;
      end
      CMD_LOAD_X: x_vec[idx] = val;
      CMD_LOAD_W: weight[idx] = val;
      CMD_ELEM: begin
        if (row_pos < nrows) begin
          bank = (row_pos % 2) * MaxCols;
          if (col_pos >= MaxCols) col_pos = MaxCols - 1;
          row_buf[bank + col_pos] = val;
          dot_sum = add_sat(dot_sum, mul_q16(val, x_vec[col_pos]));
          // A row ends once the column position reaches the current width.
          if (col_pos + 1 >= ncols) begin
            scaled = mul_q16(dot_sum, weight[row_pos]);
            for (int j = 0; j < ncols; j++)
              col_acc[j] = add_sat(col_acc[j], mul_q16(row_buf[bank + j], scaled));
            dot_sum = '0;
            col_pos = 0;
            row_pos++;
          end else begin
            col_pos++;
          end
        end
      end
      CMD_READ: begin
        if (idx < nrows) begin
          r.idx = idx;
          r.val = add_sat((idx < ncols) ? col_acc[idx] : 32'sd0, weight[idx]);
          expected_reads.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    read_result_t exp_r;
    if (rst) begin
      foreach (x_vec[i]) x_vec[i] = '0;
      foreach (weight[i]) weight[i] = '0;
      foreach (col_acc[i]) col_acc[i] = '0;
      foreach (row_buf[i]) row_buf[i] = '0;
      row_pos  = 0;
      col_pos  = 0;
      dot_sum  = '0;
      rows_reg = 11'd1024;
      cols_reg = 11'd1024;
      expected_reads.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegRowCount) rows_reg = cfg_data;
        else cols_reg = cfg_data;
      end
      // Compare a returned item before queuing new expectations.
      if (m_tvalid && m_tready) begin
        results++;
        if (expected_reads.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result idx=%0d val=%0d", $realtime,
                     m_tdata[9:0], $signed(m_tdata[41:10]));
        end else begin
          exp_r = expected_reads.pop_front();
          if (m_tdata[9:0] !== exp_r.idx || $signed(m_tdata[41:10]) !== exp_r.val) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected idx=%0d val=%0d, got idx=%0d val=%0d",
                       $realtime, exp_r.idx, exp_r.val, m_tdata[9:0],
                       $signed(m_tdata[41:10]));
          end
        end
      end
      if (s_tvalid && s_tready) apply_command(s_tdata);
    end
    pending = expected_reads.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
    results = 0;
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import wgm_pkg::*;
  import wgm_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // command[2:0], index[12:3], value[44:13]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // out_index[9:0], out_value[41:10]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;

  int errors, pending, results;
  int items_sent = 0;
  int phases = 0;
  int send_mode = 1, recv_mode = 1, stall_left = 0;
  int unsigned eff_rows = 1024, eff_cols = 1024;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  weighted_gram_matrix_vector_product_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wgm_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results(results)
  );

  // Mostly no pause or a short one, now and then a long one; mode zero means none.
  function automatic int pause_len(input int mode);
    if (mode == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Receiver back-pressure with occasional changes of mode.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) recv_mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = pause_len(recv_mode);
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  task automatic send(input logic [2:0] cmd, input logic [9:0] idx,
                      input logic [31:0] val);
    int gap;
    gap = pause_len(send_mode);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, val, idx, cmd};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if ($urandom_range(0, 99) == 0) send_mode = $urandom_range(0, 2);
  endtask

  function automatic int unsigned clamp_size(input logic [10:0] v);
    if (v < 1) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  // Wait for all reads to return, then for a row update and a clearing sweep.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4 * eff_cols + 1200) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegRowCount) eff_rows = clamp_size(v);
    else eff_cols = clamp_size(v);
  endtask

  function automatic logic [31:0] data_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic logic [2:0] unused_cmd();
    return 3'($urandom_range(UnusedCmdFirst, UnusedCmdLast));
  endfunction

  // One random job: size, load, stream the matrix, read back.
  task automatic random_phase();
    int unsigned n_elem;
    logic [10:0] r, c;
    r = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6);
    c = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
    write_reg(RegRowCount, r);
    write_reg(RegColumnCount, c);
    for (int i = 0; i < eff_cols; i++) send(CMD_LOAD_X, 10'(i), data_word());
    for (int i = 0; i < eff_rows; i++) send(CMD_LOAD_W, 10'(i), data_word());
    send(CMD_START, 10'($urandom()), $urandom());
    n_elem = eff_rows * eff_cols;
    case ($urandom_range(0, 5))
      0: n_elem = $urandom_range(0, n_elem);
      1: n_elem += $urandom_range(1, 3);
      default: ;
    endcase
    for (int i = 0; i < n_elem; i++) begin
      if ($urandom_range(0, 19) == 0)
        send(unused_cmd(), 10'($urandom()), $urandom());
      send(CMD_ELEM, 10'($urandom()), data_word());
    end
    for (int i = 0; i < eff_rows + 2; i++) begin
      if ($urandom_range(0, 3) == 0) send(CMD_READ, 10'($urandom_range(0, 1023)), $urandom());
      else send(CMD_READ, 10'($urandom_range(0, eff_rows - 1)), $urandom());
    end
    phases++;
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest sizes through clamping, extreme words, out-of-range read, ignored codes.
    write_reg(RegRowCount, 11'd0);
    write_reg(RegColumnCount, 11'd0);
    send(CMD_LOAD_X, 10'd0, 32'h7FFFFFFF);
    send(CMD_LOAD_W, 10'd0, 32'h80000000);
    send(CMD_START, 10'd0, 32'd0);
    send(CMD_ELEM, 10'd0, 32'h7FFFFFFF);
    send(CMD_READ, 10'd0, 32'd0);
    send(CMD_READ, 10'd1, 32'd0);
    send(3'(UnusedCmdFirst), 10'h3FF, 32'hFFFFFFFF);
    send(3'(UnusedCmdLast), 10'd0, 32'd0);
    settle();

    // Width shrinks while a row is half done: the next element closes the row.
    write_reg(RegRowCount, 11'd3);
    write_reg(RegColumnCount, 11'd4);
    for (int i = 0; i < 4; i++) send(CMD_LOAD_X, 10'(i), 32'h00010000 * (i + 1));
    for (int i = 0; i < 3; i++) send(CMD_LOAD_W, 10'(i), 32'h00008000);
    send(CMD_START, 10'd0, 32'd0);
    for (int i = 0; i < 6; i++) send(CMD_ELEM, 10'd0, 32'h00020000);
    settle();
    write_reg(RegColumnCount, 11'd2);
    send(CMD_ELEM, 10'd0, 32'hFFFF0000);
    for (int i = 0; i < 3; i++) send(CMD_READ, 10'(i), 32'd0);
    settle();

    // Largest sizes through clamping; rows stay partial so no huge update runs.
    write_reg(RegRowCount, 11'd2047);
    write_reg(RegColumnCount, 11'd2047);
    send(CMD_LOAD_W, 10'd1023, 32'h7FFFFFFF);
    send(CMD_START, 10'd0, 32'd0);
    send(CMD_ELEM, 10'd0, 32'h12345678);
    send(CMD_READ, 10'd0, 32'd0);
    send(CMD_READ, 10'd1023, 32'd0);
    settle();
    write_reg(RegRowCount, 11'd1024);
    write_reg(RegColumnCount, 11'd1024);
    send(CMD_READ, 10'd1023, 32'd0);
    settle();

    while (items_sent < 1725) random_phase();
    settle();

    $display("Sent %0d items in %0d random jobs plus directed cases; %0d reads returned.",
             items_sent, phases, results);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("Timeout with %0d reads outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
